// ===== hdl/swlm_pkg.sv =====
package swlm_pkg;

    // Window depth and sample width
    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 32;

    // Width of the window_size register
    localparam int CFG_W = 7;

    // Cell index / arrival tag width, and a count that can hold WINDOW_MAX
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = CFG_W'(3);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;

    // One window entry: sample value plus the ring slot it arrived in
    typedef struct packed {
        t_sample          value;
        logic [IDX_W-1:0] tag;
    } t_entry;

    // Flags one cell hands to its right neighbor
    typedef struct packed {
        logic gt;   // entry is above the incoming sample (or empty)
        logic ge;   // entry sits at or after the one being removed
    } t_link;

endpackage

// ===== hdl/swlm_cell.sv =====
module swlm_cell import swlm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic             i_valid,
    input  t_entry           i_key,
    input  logic [IDX_W-1:0] i_oldest,
    input  logic             i_full,
    input  logic             i_ge,
    input  t_link            i_left,
    input  t_entry           i_left_entry,
    input  logic             i_right_gt,
    input  t_entry           i_right_entry,
    output t_entry           o_entry,
    output logic             o_gt,
    output logic             o_hit
);

    t_entry r_entry;
    t_entry n_entry;
    t_entry s_self;
    t_entry s_left;
    logic   gs_self;
    logic   gs_left;

    // Local compares: against the new sample and against the leaving tag
    always_comb begin
        o_gt  = !i_valid || ($signed(r_entry.value) > $signed(i_key.value));
        o_hit = i_full && i_valid && (r_entry.tag == i_oldest);
    end

    // Compact around the removed entry, then open a gap for the new one
    always_comb begin
        s_self  = i_ge ? i_right_entry : r_entry;
        gs_self = i_ge ? i_right_gt    : o_gt;
        s_left  = i_left.ge ? r_entry : i_left_entry;
        gs_left = i_left.ge ? o_gt    : i_left.gt;
        if (!gs_self) begin
            n_entry = s_self;
        end else if (gs_left) begin
            n_entry = s_left;
        end else begin
            n_entry = i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== hdl/swlm_out.sv =====
module swlm_out import swlm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_result,
    input  t_sample          i_values [WINDOW_MAX],
    input  logic [IDX_W-1:0] i_sel,
    input  logic             i_ready,
    output logic             o_take,
    output logic             o_valid,
    output t_sample          o_median
);

    logic    r_pend;
    logic    r_valid;
    t_sample r_median;
    logic    move;

    // Pending result moves into the output register when it is free
    assign move   = r_pend && (!r_valid || i_ready);
    assign o_take = !r_pend || !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_pend <= i_result || (r_pend && !move);
            if (move) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Pick the median rank out of the sorted cells
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_median <= i_values[i_sel];
        end
    end

    assign o_valid  = r_valid;
    assign o_median = r_median;

endmodule

// ===== hdl/sliding_window_lower_median.sv =====
// Sliding-window lower median filter.
// Input channel: i_sample with i_sample_valid / o_sample_ready; one signed
// sample per transfer. Output channel: o_median with o_median_valid /
// i_median_ready; one result per input once the window holds window_size
// samples, and none before that.
// The result is the element of rank ceil(k/2) of the last k samples in
// ascending order (k = window_size, 0 taken as 1, above 64 taken as 64).
// Configuration: i_cfg_we / i_cfg_wdata write window_size and
// restart the fill from empty; write only while the block is idle.
// Throughput: one sample per cycle while o_sample_ready is high. A row
// of 64 cells keeps the window sorted; each accepted sample updates every
// cell in the same cycle. Result path: the transfer edge updates the cells
// and marks the result pending; the median is then selected into the
// output register as soon as that register is free.
// Reset: window_size returns to 3 and the window empties; nothing is output.
// Stall: a finished result waits in the output register while one more
// result waits in the cells; o_sample_ready drops only when both are held.
module sliding_window_lower_median import swlm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_sample_valid,
    output logic             o_sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic             o_median_valid,
    input  logic             i_median_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_median
);

    logic [CFG_W-1:0] r_window_size;
    logic [CNT_W-1:0] r_fill;
    logic [IDX_W-1:0] r_wp;

    logic [CNT_W-1:0] k_eff;
    logic             full;
    logic             accept;
    logic             result;
    logic [CNT_W:0]   old_sum;
    logic [IDX_W-1:0] oldest;
    logic [IDX_W-1:0] rm_pos;
    logic [IDX_W-1:0] med_sel;
    t_entry           key;

    t_entry  entries   [WINDOW_MAX];
    t_entry  left_ent  [WINDOW_MAX];
    t_entry  right_ent [WINDOW_MAX];
    t_link   left_lnk  [WINDOW_MAX];
    t_sample values    [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] gt;
    logic [WINDOW_MAX-1:0] hit;
    logic [WINDOW_MAX-1:0] ge;
    logic [WINDOW_MAX-1:0] occ;
    logic [WINDOW_MAX-1:0] right_gt;

    // Effective window length
    always_comb begin
        if (r_window_size == '0) begin
            k_eff = CNT_W'(1);
        end else if (int'(r_window_size) > WINDOW_MAX) begin
            k_eff = CNT_W'(WINDOW_MAX);
        end else begin
            k_eff = CNT_W'(r_window_size);
        end
    end

    assign full    = (r_fill == k_eff);
    assign accept  = i_sample_valid && o_sample_ready;
    assign result  = accept && (full || ((r_fill + CNT_W'(1)) == k_eff));
    assign key     = '{value: i_sample, tag: r_wp};
    assign med_sel = IDX_W'((k_eff - CNT_W'(1)) >> 1);

    // Ring slot of the sample that leaves when the window is full
    always_comb begin
        old_sum = (CNT_W+1)'(r_wp) + (CNT_W+1)'(WINDOW_MAX) - (CNT_W+1)'(k_eff);
        if (old_sum >= (CNT_W+1)'(WINDOW_MAX)) begin
            oldest = IDX_W'(old_sum - (CNT_W+1)'(WINDOW_MAX));
        end else begin
            oldest = IDX_W'(old_sum);
        end
    end

    // Position of the leaving entry; cells from there on shift left
    always_comb begin
        rm_pos = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (hit[i]) begin
                rm_pos = rm_pos | IDX_W'(i);
            end
        end
        for (int i = 0; i < WINDOW_MAX; i++) begin
            ge[i]  = full && (IDX_W'(i) >= rm_pos);
            occ[i] = i < int'(r_fill);
        end
    end

    // Neighbor wiring, with fixed values past both ends of the row
    always_comb begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
            values[i] = entries[i].value;
            if (i == 0) begin
                left_ent[i] = '0;
                left_lnk[i] = '{gt: 1'b0, ge: 1'b0};
            end else begin
                left_ent[i] = entries[i-1];
                left_lnk[i] = '{gt: gt[i-1], ge: ge[i-1]};
            end
            if (i == WINDOW_MAX - 1) begin
                right_ent[i] = '0;
                right_gt[i]  = 1'b1;
            end else begin
                right_ent[i] = entries[i+1];
                right_gt[i]  = gt[i+1];
            end
        end
    end

    // Sorted row of cells
    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        swlm_cell u_cell (
            .i_clk         (i_clk),
            .i_load        (accept),
            .i_valid       (occ[g]),
            .i_key         (key),
            .i_oldest      (oldest),
            .i_full        (full),
            .i_ge          (ge[g]),
            .i_left        (left_lnk[g]),
            .i_left_entry  (left_ent[g]),
            .i_right_gt    (right_gt[g]),
            .i_right_entry (right_ent[g]),
            .o_entry       (entries[g]),
            .o_gt          (gt[g]),
            .o_hit         (hit[g])
        );
    end

    // Output stage
    swlm_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (result),
        .i_values (values),
        .i_sel    (med_sel),
        .i_ready  (i_median_ready),
        .o_take   (o_sample_ready),
        .o_valid  (o_median_valid),
        .o_median (o_median)
    );

    // Config register, fill count and ring slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_SIZE_RESET;
            r_fill        <= '0;
            r_wp          <= '0;
        end else if (i_cfg_we) begin
            r_window_size <= i_cfg_wdata;
            r_fill        <= '0;
            r_wp          <= '0;
        end else if (accept) begin
            if (!full) begin
                r_fill <= r_fill + CNT_W'(1);
            end
            if (r_wp == IDX_W'(WINDOW_MAX - 1)) begin
                r_wp <= '0;
            end else begin
                r_wp <= r_wp + IDX_W'(1);
            end
        end
    end

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= k_eff)
        else $error("fill count above window length");

    a_one_leaver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> $onehot(hit))
        else $error("full window without exactly one leaving entry");

    a_stall_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_sample_ready |-> (o_median_valid && !i_median_ready))
        else $error("input blocked while output is free");

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import swlm_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS  = 430;

    // One row of the directed table: a window_size write or a sample transfer
    typedef struct {
        bit               is_cfg;
        logic [CFG_W-1:0] cfg;
        t_sample          smp;
        bit               typed;
        t_sample          med;
    } t_dir_row;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_cfg_we       = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata    = '0;
    logic             i_sample_valid = 1'b0;
    logic             o_sample_ready;
    t_sample          i_sample       = '0;
    logic             o_median_valid;
    logic             i_median_ready = 1'b0;
    t_sample          o_median;

    // Predictor state: samples in arrival order and the same samples sorted
    t_sample window_hist[$];
    t_sample window_sorted[$];
    int      window_k;
    t_sample median_due[$];

    int err_cnt      = 0;
    int cycle_cnt    = 0;
    int src_idle_pct = 36;
    int dst_idle_pct = 86;
    int hold_req     = 0;
    int hold_left    = 0;

    logic [CFG_W-1:0] corner_cfgs [7] = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd65, 7'd127, 7'd3};

    // Directed rows; typed medians are the ones obvious from the window
    t_dir_row dir_tab [28] = '{
        // reset window of 3, full-scale samples
        '{1'b0, 7'd0, 32'sh7FFFFFFF, 1'b0, 32'sd0},
        '{1'b0, 7'd0, 32'sh80000000, 1'b0, 32'sd0},
        '{1'b0, 7'd0, 32'sd0,        1'b1, 32'sd0},
        '{1'b0, 7'd0, -32'sd1,       1'b1, -32'sd1},
        // size zero acts as pass-through
        '{1'b1, 7'd0, 32'sd0,        1'b0, 32'sd0},
        '{1'b0, 7'd0, 32'sh80000000, 1'b1, 32'sh80000000},
        '{1'b0, 7'd0, 32'sh7FFFFFFF, 1'b1, 32'sh7FFFFFFF},
        '{1'b0, 7'd0, 32'sh55555555, 1'b1, 32'sh55555555},
        '{1'b0, 7'd0, 32'shAAAAAAAA, 1'b1, 32'shAAAAAAAA},
        // size two gives the minimum, equal samples included
        '{1'b1, 7'd2, 32'sd0,        1'b0, 32'sd0},
        '{1'b0, 7'd0, 32'sd10,       1'b0, 32'sd0},
        '{1'b0, 7'd0, -32'sd3,       1'b1, -32'sd3},
        '{1'b0, 7'd0, 32'sd10,       1'b1, -32'sd3},
        '{1'b0, 7'd0, 32'sd10,       1'b1, 32'sd10},
        // oversize windows saturate; partial fills are dropped by the next write
        '{1'b1, 7'd65, 32'sd0,       1'b0, 32'sd0},
        '{1'b0, 7'd0, 32'sd1,        1'b0, 32'sd0},
        '{1'b0, 7'd0, -32'sd1,       1'b0, 32'sd0},
        '{1'b1, 7'd127, 32'sd0,      1'b0, 32'sd0},
        '{1'b0, 7'd0, 32'sd5,        1'b0, 32'sd0},
        '{1'b1, 7'd1, 32'sd0,        1'b0, 32'sd0},
        '{1'b0, 7'd0, 32'sh7FFFFFFF, 1'b1, 32'sh7FFFFFFF},
        // even size takes the lower of the two middle entries
        '{1'b1, 7'd4, 32'sd0,        1'b0, 32'sd0},
        '{1'b0, 7'd0, 32'sd3,        1'b0, 32'sd0},
        '{1'b0, 7'd0, 32'sd3,        1'b0, 32'sd0},
        '{1'b0, 7'd0, 32'sd3,        1'b0, 32'sd0},
        '{1'b0, 7'd0, 32'sd3,        1'b1, 32'sd3},
        '{1'b0, 7'd0, 32'sd1,        1'b1, 32'sd3},
        '{1'b0, 7'd0, 32'sd1,        1'b1, 32'sd1}
    };

    sliding_window_lower_median dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_median_valid (o_median_valid),
        .i_median_ready (i_median_ready),
        .o_median       (o_median)
    );

    // Clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Register value to window length: zero means one, capped at the depth
    function automatic int window_len(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > WINDOW_MAX)
            return WINDOW_MAX;
        return int'(v);
    endfunction

    // Slide the window by one sample and queue the lower median once full
    function automatic void track_window(input t_sample smp, input bit typed,
                                         input t_sample typed_med);
        t_sample oldest;
        int      pos;
        if (window_hist.size() == window_k) begin
            oldest = window_hist.pop_front();
            pos = 0;
            while (pos < window_sorted.size() && window_sorted[pos] != oldest)
                pos++;
            window_sorted.delete(pos);
        end
        window_hist = {window_hist, smp};
        pos = 0;
        while (pos < window_sorted.size() && window_sorted[pos] <= smp)
            pos++;
        window_sorted.insert(pos, smp);
        if (window_hist.size() == window_k)
            median_due = {median_due,
                          typed ? typed_med : window_sorted[(window_k + 1) / 2 - 1]};
    endfunction

    function automatic t_sample rand_sample();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 30)
            return t_sample'(int'($urandom_range(8)) - 4);   // dense, many ties
        if (sel < 40) begin
            case ($urandom_range(3))
                0: return 32'sh7FFFFFFF;
                1: return 32'sh80000000;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return t_sample'($urandom());
    endfunction

    // Offer one sample; entered and left at a falling edge with valid kept high
    task automatic send_sample(input t_sample smp, input bit typed, input t_sample med);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            i_sample_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample       <= smp;
        @(posedge i_clk);
        while (!o_sample_ready)
            @(posedge i_clk);
        track_window(smp, typed, med);
        @(negedge i_clk);
    endtask

    // Wait until every queued median is out and the pipeline is empty
    task automatic wait_drained();
        while (median_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_window_size(input logic [CFG_W-1:0] val);
        i_sample_valid <= 1'b0;
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        window_k = window_len(val);
        window_hist.delete();
        window_sorted.delete();
    endtask

    // Result side: random stalls plus an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_median_ready <= 1'b0;
        end else begin
            i_median_ready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Compare each result transfer with the oldest queued median
    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && o_median_valid && i_median_ready) begin
            if (median_due.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("median %0d arrived with nothing expected", o_median);
            end else begin
                want = median_due.pop_front();
                if (o_median !== want) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("median mismatch: expected %0d, got %0d", want, o_median);
                end
            end
        end
    end

    // Stimulus
    initial begin
        int               seg;
        int               seg_in_phase;
        int               sent;
        int               n;
        logic [CFG_W-1:0] cfg;
        window_k = window_len(WINDOW_SIZE_RESET);
        seg = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, under the first idling setting
        foreach (dir_tab[r]) begin
            if (dir_tab[r].is_cfg)
                write_window_size(dir_tab[r].cfg);
            else
                send_sample(dir_tab[r].smp, dir_tab[r].typed, dir_tab[r].med);
        end

        // random segments, each under its own window size
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 86 : 0;
            dst_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 36 : 0;
            sent = 0;
            seg_in_phase = 0;
            while (sent < PHASE_ITEMS) begin
                if (seg < 7)
                    cfg = corner_cfgs[seg];
                else if ($urandom_range(9) < 7)
                    cfg = CFG_W'($urandom_range(1, 9));
                else
                    cfg = CFG_W'($urandom_range(0, 127));
                write_window_size(cfg);
                // long result hold-off while samples keep coming: fills the block
                if (ph == 2 && seg_in_phase == 0)
                    hold_req = 300;
                n = window_len(cfg) + $urandom_range(10, 50);
                repeat (n) send_sample(rand_sample(), 1'b0, '0);
                sent += n;
                seg++;
                seg_in_phase++;
            end
        end

        i_sample_valid <= 1'b0;
        wait_drained();
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/swlm_pkg.sv
hdl/swlm_cell.sv
hdl/swlm_out.sv
hdl/sliding_window_lower_median.sv
tb/testbench.sv
